// ===== rtl/md5_pkg.sv =====
package md5_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } md5_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } md5_out_t;

    // Front-to-back command: one message word of 32 bits with its slot, flagged at block end and at finish.
    typedef struct packed {
        logic [31:0] word;
        logic [3:0]  slot;
        logic        block_end;
        logic        finish;
    } md5_cmd_t;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;

    function automatic logic [31:0] round_const(input logic [5:0] k);
        logic [31:0] t [64];
        t = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        return t[k];
    endfunction

    function automatic logic [4:0] rot_amount(input logic [3:0] i);
        logic [4:0] t [16];
        t = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
              5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
        return t[i];
    endfunction

endpackage

// ===== rtl/md5_front.sv =====
module md5_front (
    input  logic               clk,
    input  logic               rst_n,
    input  md5_pkg::md5_in_t   in_item,
    input  logic               in_valid,
    output logic               in_stall,
    output md5_pkg::md5_cmd_t  cmd,
    output logic               cmd_valid,
    input  logic               cmd_full
);
    import md5_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PAD  = 2'd1;

    logic [1:0]  state_reg, state_next;
    logic [60:0] count_reg, count_next;   // byte count; bits = count << 3
    logic [23:0] acc_reg;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] bits_reg, bits_next;
    logic        mark_reg, mark_next;       // next pad byte is the 0x80 marker
    logic        len_blk_reg, len_blk_next; // this pad block carries the length

    logic        take;
    logic        push;
    logic        finishing;
    logic [7:0]  cur_byte;

    assign in_stall  = (state_reg != ST_IDLE) || cmd_full;
    assign take      = in_valid && !in_stall;
    assign finishing = (state_reg == ST_PAD) && !cmd_full && (pos_reg == 6'd63)
                       && len_blk_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        bits_next    = bits_reg;
        mark_next    = mark_reg;
        len_blk_next = len_blk_reg;
        cur_byte     = 8'h00;
        push         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && in_item.byte_valid)
                begin
                    cur_byte   = in_item.data_byte;
                    push       = 1'b1;
                    count_next = count_reg + 61'd1;
                    pos_next   = pos_reg + 6'd1;
                end
                if (take && in_item.last)
                begin
                    state_next   = ST_PAD;
                    bits_next    = {count_next, 3'b000};
                    count_next   = '0;
                    mark_next    = 1'b1;
                    // the marker must land before the length window
                    len_blk_next = (pos_next < LEN_POS);
                end
            end
            ST_PAD:
            begin
                if (!cmd_full)
                begin
                    push      = 1'b1;
                    pos_next  = pos_reg + 6'd1;
                    mark_next = 1'b0;
                    if (mark_reg)
                        cur_byte = PAD_BYTE;
                    else if (len_blk_reg && pos_reg >= LEN_POS)
                        cur_byte = bits_reg[{pos_reg[2:0], 3'b000} +: 8];
                    if (pos_reg == 6'd63)
                    begin
                        if (len_blk_reg)
                            state_next = ST_IDLE;
                        else
                            len_blk_next = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign cmd_valid      = push && (pos_reg[1:0] == 2'd3);
    assign cmd.word       = {cur_byte, acc_reg};
    assign cmd.slot       = pos_reg[5:2];
    assign cmd.block_end  = (pos_reg == 6'd63);
    assign cmd.finish     = finishing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pos_reg     <= '0;
            mark_reg    <= 1'b0;
            len_blk_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            mark_reg    <= mark_next;
            len_blk_reg <= len_blk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= push ? {cur_byte, acc_reg[23:8]} : acc_reg;
        bits_reg <= bits_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd.finish |-> cmd.block_end)
        else $error("finish without block end");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> pos_reg[1:0] == 2'd3)
        else $error("word pushed off alignment");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PAD |-> in_stall)
        else $error("input taken while padding");

endmodule

// ===== rtl/md5_queue.sv =====
module md5_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  md5_pkg::md5_cmd_t  wr_data,
    input  logic               wr_en,
    output logic               full,
    output md5_pkg::md5_cmd_t  rd_data,
    output logic               rd_valid,
    input  logic               rd_en
);
    import md5_pkg::*;

    md5_cmd_t    mem_reg [4];
    logic [1:0]  wp_reg, rp_reg;
    logic [2:0]  cnt_reg;

    // full leaves room for the word being assembled
    assign full     = (cnt_reg >= 3'd3);
    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 2'd1;
            if (rd_en)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b00, wr_en} - {2'b00, rd_en};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && cnt_reg == 3'd4))
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> rd_valid)
        else $error("queue underflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("queue count out of range");

endmodule

// ===== rtl/md5_back.sv =====
module md5_back (
    input  logic               clk,
    input  logic               rst_n,
    input  md5_pkg::md5_cmd_t  cmd,
    input  logic               cmd_valid,
    output logic               cmd_take,
    output md5_pkg::md5_out_t  out_item,
    output logic               valid,
    input  logic               stall
);
    import md5_pkg::*;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]  state_reg;
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  k_reg;
    logic        fin_reg;
    logic [1:0]  idx_reg;
    logic        val_reg;

    logic [1:0]  phase;
    logic [31:0] f;
    logic [3:0]  g;
    logic [31:0] t, rot, new_b;
    logic [4:0]  s;

    assign phase = k_reg[5:4];

    always_comb
    begin
        unique case (phase)
            2'd0: begin f = (b_reg & c_reg) | (~b_reg & d_reg); g = k_reg[3:0]; end
            2'd1: begin f = (b_reg & d_reg) | (c_reg & ~d_reg);
                        g = 4'(5 * k_reg[3:0] + 1); end
            2'd2: begin f = b_reg ^ c_reg ^ d_reg; g = 4'(3 * k_reg[3:0] + 5); end
            default: begin f = c_reg ^ (b_reg | ~d_reg); g = 4'(7 * k_reg[3:0]); end
        endcase
        t     = a_reg + f + w_reg[g] + round_const(k_reg);
        s     = rot_amount({phase, k_reg[1:0]});
        rot   = (t << s) | (t >> (6'd32 - {1'b0, s}));
        new_b = b_reg + rot;
    end

    assign cmd_take = (state_reg == ST_LOAD) && cmd_valid;
    assign valid    = val_reg;
    assign out_item.digest_word = h_reg[idx_reg];
    assign out_item.word_index  = idx_reg;
    assign out_item.last_word   = (idx_reg == 2'd3);

    always_ff @(posedge clk)
    begin
        if (cmd_take)
            w_reg[cmd.slot] <= cmd.word;
        if (cmd_take && cmd.block_end)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
        end
        else if (state_reg == ST_RUN)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= new_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            k_reg     <= '0;
            fin_reg   <= 1'b0;
            idx_reg   <= '0;
            val_reg   <= 1'b0;
            h_reg     <= '{IV_A, IV_B, IV_C, IV_D};
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (cmd_take && cmd.block_end)
                    begin
                        state_reg <= ST_RUN;
                        k_reg     <= '0;
                        fin_reg   <= cmd.finish;
                    end
                end
                ST_RUN:
                begin
                    k_reg <= k_reg + 6'd1;
                    if (k_reg == 6'd63)
                    begin
                        h_reg[0] <= h_reg[0] + d_reg;
                        h_reg[1] <= h_reg[1] + new_b;
                        h_reg[2] <= h_reg[2] + b_reg;
                        h_reg[3] <= h_reg[3] + c_reg;
                        if (fin_reg)
                        begin
                            state_reg <= ST_EMIT;
                            idx_reg   <= '0;
                            val_reg   <= 1'b1;
                        end
                        else
                            state_reg <= ST_LOAD;
                    end
                end
                ST_EMIT:
                begin
                    if (!stall)
                    begin
                        idx_reg <= idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                        begin
                            val_reg   <= 1'b0;
                            state_reg <= ST_LOAD;
                            h_reg     <= '{IV_A, IV_B, IV_C, IV_D};
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> state_reg == ST_EMIT)
        else $error("digest shown outside emit");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> !cmd_take)
        else $error("word taken mid-compression");
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && out_item.last_word && !stall |=> !valid)
        else $error("digest overrun");

endmodule

// ===== rtl/md5_message_digest.sv =====
// MD5 digest of a byte stream.
// Input channel: in_item (data_byte, byte_valid, last) with in_valid/in_stall.
// Each accepted word with byte_valid appends one byte. A word with last ends the
// message: padding and the bit length are appended, which takes one or two blocks.
// Output channel: out_item (digest_word, word_index, last_word) with
// out_valid/out_stall; four words per message, A first, last_word on D.
// Throughput: one byte per cycle while the front fills a block and the queue
// is not full; the back runs the rounds of each block on the round unit, and
// only the three queued words plus the word being packed (12 to 15 bytes)
// overlap those rounds. Padding sends one pad byte per cycle while the queue
// is not full. From last to first digest word come the pad bytes of the final
// block, the queue register and the final block's rounds; a two-block pad
// adds the first block's rounds.
// Reset returns the chaining words to the initial vector, clears the bit count
// and empties the queue. A stalled digest word holds until taken; the input
// stalls while padding runs or while the queue is full.
module md5_message_digest (
    input  logic              clk,
    input  logic              rst_n,
    input  md5_pkg::md5_in_t  in_item,
    input  logic              in_valid,
    output logic              in_stall,
    output md5_pkg::md5_out_t out_item,
    output logic              out_valid,
    input  logic              out_stall
);
    import md5_pkg::*;

    md5_cmd_t f_cmd, q_cmd;
    logic     f_valid, q_full, q_valid, q_take;

    md5_front u_front (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .in_valid(in_valid),
        .in_stall(in_stall), .cmd(f_cmd), .cmd_valid(f_valid), .cmd_full(q_full));

    md5_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_data(f_cmd), .wr_en(f_valid), .full(q_full),
        .rd_data(q_cmd), .rd_valid(q_valid), .rd_en(q_take));

    md5_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd(q_cmd), .cmd_valid(q_valid),
        .cmd_take(q_take), .out_item(out_item), .valid(out_valid), .stall(out_stall));

endmodule

// ===== bench/md5_message_digest_tb.sv =====
module md5_message_digest_tb;
    import md5_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 400;
    localparam int HOLD_CYCLES = 600;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic     clk;
    logic     rst_n;
    md5_in_t  in_item;
    logic     in_valid;
    logic     in_stall;
    md5_out_t out_item;
    logic     out_valid;
    logic     out_stall;

    md5_in_t    byte_queue[$];
    md5_out_t   digest_queue[$];
    idle_mode_t idle_mode;
    int         error_count;
    int         cycle_count;
    int         hold_off;
    bit         hold_req;
    bit         hold_used;

    // Predictor state: chaining words, bit count, block buffer.
    logic [31:0] hash_state[4];
    logic [63:0] bit_count;
    logic [7:0]  block_buf[64];

    md5_message_digest DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_item (out_item),
        .out_valid(out_valid),
        .out_stall(out_stall)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] sine_const(input int k);
        logic [31:0] t [64];
        t = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        return t[k];
    endfunction

    function automatic int shift_amount(input int k);
        int t [16];
        t = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        return t[((k >> 4) << 2) | (k & 3)];
    endfunction

    task automatic compress;
        logic [31:0] w[16];
        logic [31:0] a, b, c, d, f, t;
        int          g;
        begin
            a = hash_state[0];
            b = hash_state[1];
            c = hash_state[2];
            d = hash_state[3];
            for (int k = 0; k < 16; k++)
                w[k] = {block_buf[4*k+3], block_buf[4*k+2], block_buf[4*k+1], block_buf[4*k]};
            for (int k = 0; k < 64; k++)
            begin
                case (k >> 4)
                    0: begin f = (b & c) | (~b & d); g = k; end
                    1: begin f = (b & d) | (c & ~d); g = (5*k + 1) & 15; end
                    2: begin f = b ^ c ^ d; g = (3*k + 5) & 15; end
                    default: begin f = c ^ (b | ~d); g = (7*k) & 15; end
                endcase
                t = a + f + w[g] + sine_const(k);
                t = b + ((t << shift_amount(k)) | (t >> (32 - shift_amount(k))));
                a = d;
                d = c;
                c = b;
                b = t;
            end
            hash_state[0] += a;
            hash_state[1] += b;
            hash_state[2] += c;
            hash_state[3] += d;
        end
    endtask

    task automatic init_hash;
        begin
            hash_state = '{IV_A, IV_B, IV_C, IV_D};
            bit_count  = '0;
        end
    endtask

    task automatic predict_digest(input md5_in_t item);
        int          pos;
        logic [63:0] bits;
        md5_out_t    exp_word;
        begin
            pos = int'(bit_count[8:3]);
            if (item.byte_valid)
            begin
                block_buf[pos] = item.data_byte;
                bit_count += 64'd8;
                pos = (pos + 1) & 63;
                if (pos == 0)
                    compress();
            end
            if (item.last)
            begin
                bits = bit_count;
                block_buf[pos] = PAD_BYTE;
                pos++;
                if (pos > int'(LEN_POS))
                begin
                    while (pos < 64)
                        block_buf[pos++] = 8'h00;
                    compress();
                    pos = 0;
                end
                while (pos < int'(LEN_POS))
                    block_buf[pos++] = 8'h00;
                for (int k = 0; k < 8; k++)
                    block_buf[56 + k] = bits[8*k +: 8];
                compress();
                for (int k = 0; k < 4; k++)
                begin
                    exp_word.digest_word = hash_state[k];
                    exp_word.word_index  = 2'(k);
                    exp_word.last_word   = (k == 3);
                    digest_queue.push_back(exp_word);
                end
                init_hash();
            end
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        begin
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
            error_count++;
        end
    endtask

    function automatic md5_in_t make_item(input logic [7:0] b, input bit v, input bit l);
        md5_in_t it;
        it.data_byte  = b;
        it.byte_valid = v;
        it.last       = l;
        return it;
    endfunction

    task automatic push_message(input int len, input bit empty_tail);
        begin
            for (int i = 0; i < len; i++)
            begin
                // sprinkle idle words into the message
                if ($urandom_range(0, 15) == 0)
                    byte_queue.push_back(make_item(8'($urandom), 1'b0, 1'b0));
                byte_queue.push_back(make_item(8'($urandom),
                    1'b1, !empty_tail && (i == len - 1)));
            end
            if (empty_tail || len == 0)
                byte_queue.push_back(make_item(8'($urandom), 1'b0, 1'b1));
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                predict_digest(in_item);
            if (byte_queue.size() > 0 &&
                !((idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) &&
                  $urandom_range(0, 99) < (idle_mode == IDLE_SENDER ? 80 : 10)))
            begin
                in_item  <= byte_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            cycle_count <= 0;
        end
        else
        begin
            md5_out_t want;
            cycle_count <= cycle_count + 1;
            if (out_valid && !out_stall)
            begin
                if (digest_queue.size() == 0)
                begin
                    report("unexpected digest word", out_item.digest_word, 32'h0);
                end
                else
                begin
                    want = digest_queue.pop_front();
                    if (out_item.digest_word !== want.digest_word)
                        report("digest_word", out_item.digest_word, want.digest_word);
                    if (out_item.word_index !== want.word_index)
                        report("word_index", 32'(out_item.word_index), 32'(want.word_index));
                    if (out_item.last_word !== want.last_word)
                        report("last_word", 32'(out_item.last_word), 32'(want.last_word));
                end
            end
            if (hold_off > 0)
                out_stall <= 1'b1;
            else if (idle_mode == IDLE_RECEIVER)
                out_stall <= ($urandom_range(0, 99) < 80);
            else if (idle_mode == IDLE_BOTH)
                out_stall <= ($urandom_range(0, 99) < 10);
            else
                out_stall <= 1'b0;
        end
    end

    // long receiver hold-off, counted in its own process
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off  <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_req && !hold_used)
        begin
            hold_off  <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[md5_message_digest] ERROR");
            $finish;
        end
    end

    task automatic drain;
        begin
            while (byte_queue.size() > 0 || in_valid)
                @(posedge clk);
            // wait for the digest words still in flight
            while (digest_queue.size() > 0)
                @(posedge clk);
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        idle_mode     = IDLE_NONE;
        error_count   = 0;
        hold_req      = 1'b0;
        init_hash();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty message, extremes, pad boundaries
        byte_queue.push_back(make_item(8'h00, 1'b0, 1'b0));
        byte_queue.push_back(make_item(8'hFF, 1'b0, 1'b1));
        byte_queue.push_back(make_item(8'hFF, 1'b1, 1'b1));
        byte_queue.push_back(make_item(8'h00, 1'b1, 1'b0));
        byte_queue.push_back(make_item(8'h55, 1'b0, 1'b0));
        byte_queue.push_back(make_item(8'hAA, 1'b1, 1'b1));
        push_message(2, 1'b1);
        push_message(3, 1'b0);
        drain();
        push_message(55, 1'b0);
        push_message(56, 1'b0);
        push_message(64, 1'b1);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_mode = idle_mode_t'(ph);
            if (ph == 0)
                hold_req = 1'b1;
            for (int m = 0; m < 2; m++)
            begin
                case ($urandom_range(0, 3))
                    0: push_message($urandom_range(0, 8), 1'($urandom_range(0, 1)));
                    1: push_message($urandom_range(52, 66), 1'($urandom_range(0, 1)));
                    default: push_message($urandom_range(0, 40), 1'($urandom_range(0, 1)));
                endcase
            end
            drain();
        end
        idle_mode = IDLE_NONE;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && digest_queue.size() == 0)
            $display("[md5_message_digest] OK");
        else
            $display("[md5_message_digest] ERROR");
        $finish;
    end
endmodule
